>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> design/arsl_pkg.sv
// ----------------------------------------------------------------------------
// arsl_pkg
// Shared constants, types and the distance tables of the range linearizer.
// ----------------------------------------------------------------------------
package arsl_pkg;

  // Window and channel configuration
  localparam int unsigned WindowLength = 8;
  localparam int unsigned ChannelCount = 2;

  localparam int unsigned PosW      = $clog2(WindowLength);
  localparam int unsigned ChIdxW    = (ChannelCount > 1) ? $clog2(ChannelCount) : 1;
  localparam int unsigned RingDepth = ChannelCount * WindowLength;
  localparam int unsigned AddrW     = $clog2(RingDepth);

  // Field widths
  localparam int unsigned SampleW = 10;
  localparam int unsigned SumW    = 16;
  localparam int unsigned AvgW    = 10;
  localparam int unsigned DistW   = 7;

  // Average = floor(sum * Recip / 2^RecipShift), exact for any 16-bit sum
  localparam int unsigned RecipShift = 32;
  localparam longint unsigned RecipVal =
    ((64'd1 << RecipShift) + WindowLength - 1) / WindowLength;
  localparam int unsigned ProdW = SumW + RecipShift;

  // Distance tables
  localparam int unsigned NearCount  = 16;
  localparam int unsigned NearFirst  = 5;
  localparam int unsigned CurveCount = 59;
  localparam int unsigned CurveFirst = 22;

  localparam logic [AvgW-1:0] NearLimit [NearCount] = '{
    10'd730, 10'd700, 10'd680, 10'd610, 10'd550, 10'd490, 10'd440, 10'd410,
    10'd390, 10'd365, 10'd345, 10'd330, 10'd320, 10'd310, 10'd300, 10'd290
  };

  localparam logic [AvgW-1:0] CurveLimit [CurveCount] = '{
    10'd280, 10'd270, 10'd260, 10'd251, 10'd243, 10'd235, 10'd228, 10'd222,
    10'd215, 10'd209, 10'd204, 10'd198, 10'd193, 10'd189, 10'd184, 10'd180,
    10'd176, 10'd172, 10'd168, 10'd165, 10'd162, 10'd158, 10'd155, 10'd152,
    10'd150, 10'd147, 10'd144, 10'd142, 10'd139, 10'd137, 10'd135, 10'd132,
    10'd130, 10'd128, 10'd126, 10'd125, 10'd123, 10'd121, 10'd119, 10'd117,
    10'd116, 10'd114, 10'd113, 10'd111, 10'd110, 10'd108, 10'd107, 10'd106,
    10'd104, 10'd103, 10'd102, 10'd101, 10'd100, 10'd98,  10'd97,  10'd96,
    10'd95,  10'd94,  10'd93
  };

  // Ring memory access
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } ring_rd_t;

  typedef struct packed {
    logic               en;
    logic [AddrW-1:0]   addr;
    logic [SampleW-1:0] data;
  } ring_wr_t;

  // Averaged reading to distance in cm
  function automatic logic [DistW-1:0] to_distance(logic [AvgW-1:0] avg);
    logic [DistW-1:0] d;
    d = DistW'(CurveFirst - 1);
    // Curve thresholds fall monotonically: the last hit is the farthest
    for (int i = 0; i < CurveCount; i++) begin
      if (avg <= CurveLimit[i]) begin
        d = DistW'(CurveFirst + i);
      end
    end
    // Near thresholds take priority; the lowest-index hit, the nearest distance, wins
    for (int i = NearCount - 1; i >= 0; i--) begin
      if (avg >= NearLimit[i]) begin
        d = DistW'(NearFirst + i);
      end
    end
    return d;
  endfunction

endpackage

>>> design/arsl_ring.sv
// ----------------------------------------------------------------------------
// arsl_ring
// Sample ring memory for all channels: one read and one write port,
// registered read, per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module arsl_ring (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  arsl_pkg::ring_rd_t               rd_i,
  input  arsl_pkg::ring_wr_t               wr_i,
  output logic [arsl_pkg::SampleW-1:0]     rdata_o
);

  logic [arsl_pkg::SampleW-1:0] mem_q [arsl_pkg::RingDepth];
  logic [arsl_pkg::RingDepth-1:0] valid_q;
  logic [arsl_pkg::SampleW-1:0] rdata_q;
  logic                         rd_valid_q;

  // Storage array and read data
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_valid_q <= valid_q[rd_i.addr];
      end
    end
  end

  assign rdata_o = rd_valid_q ? rdata_q : '0;

endmodule

>>> design/arsl_dist.sv
// ----------------------------------------------------------------------------
// arsl_dist
// Output stage: maps the averaged reading to a distance and registers
// the result item.
// ----------------------------------------------------------------------------
module arsl_dist (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          ch_i,
  input  logic [arsl_pkg::AvgW-1:0]     avg_i,
  output logic                          ch_o,
  output logic [arsl_pkg::AvgW-1:0]     avg_o,
  output logic [arsl_pkg::DistW-1:0]    dist_o
);

  logic                       ch_q;
  logic [arsl_pkg::AvgW-1:0]  avg_q;
  logic [arsl_pkg::DistW-1:0] dist_q;
  logic [arsl_pkg::DistW-1:0] dist_d;

  // Threshold lookup
  assign dist_d = arsl_pkg::to_distance(avg_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ch_q   <= ch_i;
      avg_q  <= avg_i;
      dist_q <= dist_d;
    end
  end

  assign ch_o   = ch_q;
  assign avg_o  = avg_q;
  assign dist_o = dist_q;

endmodule

>>> design/averaged_range_sensor_linearizer_core.sv
// ----------------------------------------------------------------------------
// averaged_range_sensor_linearizer_core
// Per-channel moving average of converter samples, converted to distance.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): one item is a channel tag and a
//   10-bit sample. Output channel (out_valid_o/out_ready_i): one item per
//   input item, carrying the channel, the truncated average of that
//   channel's last eight samples, and the distance in cm (5..80).
//   Pipeline: stage A, stage B, stage C, then the result register.
//   Throughput: one item per cycle unless out_ready_i holds the pipeline.
//   The sample ring is one memory read at acceptance and written back
//   when stage A advances; the per-channel sum is updated in that same
//   cycle, so consecutive items on one channel chain without a bubble.
//   Reset: ring valid bits, sums and write positions clear at once; the
//   block takes items in the first cycle after reset is released.
//   Stall: while a result waits and out_ready_i is low, the whole pipeline
//   holds and in_ready_o is low; once the result is taken, a new item is
//   accepted in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module averaged_range_sensor_linearizer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              channel_i,
  input  logic [arsl_pkg::SampleW-1:0]      sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              channel_out_o,
  output logic [arsl_pkg::AvgW-1:0]         average_o,
  output logic [arsl_pkg::DistW-1:0]        distance_cm_o
);

  localparam logic [arsl_pkg::RecipShift-1:0] Recip =
    arsl_pkg::RecipShift'(arsl_pkg::RecipVal);

  logic en;
  logic accept;
  logic ch_fold;
  logic [arsl_pkg::ChIdxW-1:0] in_idx;

  // Per-channel state
  logic [arsl_pkg::SumW-1:0] sum_q [arsl_pkg::ChannelCount];
  logic [arsl_pkg::PosW-1:0] pos_q [arsl_pkg::ChannelCount];
  logic [arsl_pkg::PosW-1:0] pos_cur;
  logic [arsl_pkg::PosW-1:0] pos_d;

  // Ring access
  arsl_pkg::ring_rd_t         ring_rd;
  arsl_pkg::ring_wr_t         ring_wr;
  logic [arsl_pkg::SampleW-1:0] ring_rdata;

  // Stage A: ring read returns, sum is updated
  logic                          a_valid_q;
  logic                          a_ch_q;
  logic [arsl_pkg::SampleW-1:0]  a_sample_q;
  logic [arsl_pkg::AddrW-1:0]    a_addr_q;
  logic [arsl_pkg::ChIdxW-1:0]   a_idx;
  logic [arsl_pkg::SumW-1:0]     a_sum_d;

  // Stage B: divide by window length
  logic                          b_valid_q;
  logic                          b_ch_q;
  logic [arsl_pkg::SumW-1:0]     b_sum_q;
  logic [arsl_pkg::ProdW-1:0]    b_prod;

  // Stage C: distance lookup
  logic                          c_valid_q;
  logic                          c_ch_q;
  logic [arsl_pkg::AvgW-1:0]     c_avg_q;
  logic [arsl_pkg::AvgW-1:0]     c_avg_d;

  logic                          out_valid_q;

  // Pipeline advances unless a result is waiting
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // Channel tag beyond the channel count folds to channel 0
  assign ch_fold = (arsl_pkg::ChannelCount > 1) ? channel_i : 1'b0;
  assign in_idx  = arsl_pkg::ChIdxW'(ch_fold);
  assign pos_cur = pos_q[in_idx];
  assign pos_d   = (pos_cur == arsl_pkg::PosW'(arsl_pkg::WindowLength - 1)) ?
                   '0 : pos_cur + 1'b1;

  // Ring read of the oldest sample at acceptance
  assign ring_rd.en   = accept;
  assign ring_rd.addr = arsl_pkg::AddrW'(in_idx) *
                        arsl_pkg::AddrW'(arsl_pkg::WindowLength) +
                        arsl_pkg::AddrW'(pos_cur);

  // Ring write-back of the new sample when stage A advances
  assign ring_wr.en   = a_valid_q && en;
  assign ring_wr.addr = a_addr_q;
  assign ring_wr.data = a_sample_q;

  arsl_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (ring_rd),
    .wr_i    (ring_wr),
    .rdata_o (ring_rdata)
  );

  // Running sum: drop the oldest sample, add the new one
  assign a_idx   = arsl_pkg::ChIdxW'(a_ch_q);
  assign a_sum_d = sum_q[a_idx] - arsl_pkg::SumW'(ring_rdata) +
                   arsl_pkg::SumW'(a_sample_q);

  // Per-channel state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < arsl_pkg::ChannelCount; i++) begin
        sum_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else begin
      if (accept) begin
        pos_q[in_idx] <= pos_d;
      end
      if (a_valid_q && en) begin
        sum_q[a_idx] <= a_sum_d;
      end
    end
  end

  // Average by reciprocal multiply
  assign b_prod  = arsl_pkg::ProdW'(b_sum_q) * arsl_pkg::ProdW'(Recip);
  assign c_avg_d = arsl_pkg::AvgW'(b_prod >> arsl_pkg::RecipShift);

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= in_valid_i;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      out_valid_q <= c_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ch_q     <= ch_fold;
      a_sample_q <= sample_i;
      a_addr_q   <= ring_rd.addr;
      b_ch_q     <= a_ch_q;
      b_sum_q    <= a_sum_d;
      c_ch_q     <= b_ch_q;
      c_avg_q    <= c_avg_d;
    end
  end

  // Distance lookup and result register
  arsl_dist u_dist (
    .clk_i  (clk_i),
    .en_i   (en),
    .ch_i   (c_ch_q),
    .avg_i  (c_avg_q),
    .ch_o   (channel_out_o),
    .avg_o  (average_o),
    .dist_o (distance_cm_o)
  );

  assign out_valid_o = out_valid_q;

  // Read and write-back never hit the same ring entry in one cycle
  `ASSERT_NEVER(a_ring_no_collision,
                ring_rd.en && ring_wr.en && (ring_rd.addr == ring_wr.addr),
                "ring read and write-back collide")

  // An accepted item enters stage A
  `ASSERT_PROP(a_accept_enters_pipe, accept |=> a_valid_q,
               "accepted item lost before stage A")

  // Distance stays within its range
  `ASSERT_PROP(a_dist_range,
               out_valid_o |-> (distance_cm_o >= 7'd5) && (distance_cm_o <= 7'd80),
               "distance out of range")

  // Small averages saturate to the far limit
  `ASSERT_PROP(a_dist_far_clamp,
               (out_valid_o && (average_o <= 10'd93)) |-> (distance_cm_o == 7'd80),
               "small average not clamped to far limit")

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks averaged_range_sensor_linearizer_core. A short table of directed
// samples runs first, then about 1800 random samples, mostly runs of one
// level per channel so that the window settles on the distance thresholds.
// An in-house model of the per-channel window and the distance mapping
// predicts every result. Both sides idle at random, the receiver holds off
// once long enough to back up the pipeline, and the sender pauses once until
// the block has drained.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTotal   = 1800;
  localparam int TailQuiet   = 150;     // last items run with no idling
  localparam int HoldAt      = 400;     // receiver holds off after this many items
  localparam int HoldCycles  = 64;
  localparam int PauseAt     = 1000;    // sender waits for a drain here
  localparam int DrainCycles = 12;
  localparam int CycleLimit  = 200000;
  localparam int DirCount    = 16;

  // Distance thresholds: near range by lower bound, curve range by upper bound
  localparam int NearEdge [16] = '{
    730, 700, 680, 610, 550, 490, 440, 410, 390, 365, 345, 330, 320, 310, 300, 290
  };
  localparam int CurveEdge [59] = '{
    280, 270, 260, 251, 243, 235, 228, 222, 215, 209, 204, 198, 193, 189, 184,
    180, 176, 172, 168, 165, 162, 158, 155, 152, 150, 147, 144, 142, 139, 137,
    135, 132, 130, 128, 126, 125, 123, 121, 119, 117, 116, 114, 113, 111, 110,
    108, 107, 106, 104, 103, 102, 101, 100, 98,  97,  96,  95,  94,  93
  };

  typedef struct packed {
    logic                       ch;
    logic [arsl_pkg::AvgW-1:0]  avg;
    logic [arsl_pkg::DistW-1:0] dist_cm;
  } range_result_t;

  typedef struct packed {
    logic                         ch;
    logic [arsl_pkg::SampleW-1:0] smp;
    logic                         known;   // expected values typed in below
    logic [arsl_pkg::AvgW-1:0]    avg;
    logic [arsl_pkg::DistW-1:0]   dist_cm;
  } directed_row_t;

  localparam directed_row_t DirectedRows [DirCount] = '{
    // right channel straight out of reset: average stays zero, farthest range
    '{1'b1, 10'd0,    1'b1, 10'd0,    7'd80},
    // fill the left window with full scale
    '{1'b0, 10'd1023, 1'b0, 10'd0,    7'd0},
    '{1'b0, 10'd1023, 1'b0, 10'd0,    7'd0},
    '{1'b0, 10'd1023, 1'b0, 10'd0,    7'd0},
    '{1'b0, 10'd1023, 1'b0, 10'd0,    7'd0},
    '{1'b0, 10'd1023, 1'b0, 10'd0,    7'd0},
    '{1'b0, 10'd1023, 1'b0, 10'd0,    7'd0},
    '{1'b0, 10'd1023, 1'b0, 10'd0,    7'd0},
    '{1'b0, 10'd1023, 1'b1, 10'd1023, 7'd5},
    // right channel is independent of the left one
    '{1'b1, 10'd1023, 1'b0, 10'd0,    7'd0},
    '{1'b1, 10'h2AA,  1'b0, 10'd0,    7'd0},
    '{1'b1, 10'h155,  1'b0, 10'd0,    7'd0},
    // left drains through the near range, wrapping the ring
    '{1'b0, 10'd0,    1'b0, 10'd0,    7'd0},
    '{1'b0, 10'd0,    1'b0, 10'd0,    7'd0},
    '{1'b0, 10'd0,    1'b0, 10'd0,    7'd0},
    '{1'b0, 10'd1,    1'b0, 10'd0,    7'd0}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         channel_i;
  logic [arsl_pkg::SampleW-1:0] sample_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic                         channel_out_o;
  logic [arsl_pkg::AvgW-1:0]    average_o;
  logic [arsl_pkg::DistW-1:0]   distance_cm_o;

  // Predictor state: per-channel sample window, sum and write slot
  logic [arsl_pkg::SampleW-1:0] window_q [2][arsl_pkg::WindowLength];
  logic [arsl_pkg::SumW-1:0]    window_sum_q [2];
  int unsigned                  write_slot_q [2];

  range_result_t pending_results [$];
  int            items_accepted = 0;
  int            error_count    = 0;
  int            cycle_count    = 0;
  bit            tail_quiet     = 1'b0;

  averaged_range_sensor_linearizer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .channel_out_o (channel_out_o),
    .average_o     (average_o),
    .distance_cm_o (distance_cm_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Averaged reading to cm: near thresholds first, then the falling curve
  function automatic logic [arsl_pkg::DistW-1:0] range_from_average(
      logic [arsl_pkg::AvgW-1:0] avg);
    for (int i = 0; i < 16; i++) begin
      if (int'(avg) >= NearEdge[i]) return arsl_pkg::DistW'(5 + i);
    end
    for (int i = 58; i >= 0; i--) begin
      if (int'(avg) <= CurveEdge[i]) return arsl_pkg::DistW'(22 + i);
    end
    return arsl_pkg::DistW'(21);
  endfunction

  // Push one sample into its channel's window and derive the result
  function automatic range_result_t advance_window(logic ch,
                                                   logic [arsl_pkg::SampleW-1:0] smp);
    range_result_t r;
    int unsigned   slot;
    slot = write_slot_q[ch];
    window_sum_q[ch] = window_sum_q[ch] - arsl_pkg::SumW'(window_q[ch][slot]) +
                       arsl_pkg::SumW'(smp);
    window_q[ch][slot] = smp;
    write_slot_q[ch] = (slot + 1) % arsl_pkg::WindowLength;
    r.ch      = ch;
    r.avg     = arsl_pkg::AvgW'(window_sum_q[ch] / arsl_pkg::WindowLength);
    r.dist_cm = range_from_average(r.avg);
    return r;
  endfunction

  // Level for a run: threshold neighborhoods, the rails, or anything
  function automatic int pick_level();
    int v;
    case ($urandom_range(0, 5))
      0:       v = NearEdge[$urandom_range(0, 15)];
      1, 2:    v = CurveEdge[$urandom_range(0, 58)];
      3:       v = $urandom_range(0, 1) ? 0 : 1023;
      default: v = $urandom_range(0, 1023);
    endcase
    v = v + int'($urandom_range(0, 2)) - 1;
    return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
  endfunction

  // Offer one item; handshake sampled at negedge, taken at the next posedge
  task automatic offer_sample(logic ch, logic [arsl_pkg::SampleW-1:0] smp, logic known,
                              logic [arsl_pkg::AvgW-1:0] kavg,
                              logic [arsl_pkg::DistW-1:0] kdist);
    range_result_t predicted;
    if (items_accepted == PauseAt) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while (pending_results.size() != 0);
      @(posedge clk_i);
    end else if (!tail_quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= smp;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    predicted = advance_window(ch, smp);
    if (known) begin
      predicted.avg     = kavg;
      predicted.dist_cm = kdist;
    end
    pending_results.push_back(predicted);
    items_accepted++;
    tail_quiet = (items_accepted >= ItemTotal - TailQuiet);
  endtask

  // Stimulus
  initial begin
    logic lane;
    int   level;
    int   run_len;
    int   v;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    channel_i  = 1'b0;
    sample_i   = '0;
    for (int c = 0; c < 2; c++) begin
      window_sum_q[c] = '0;
      write_slot_q[c] = 0;
      for (int k = 0; k < arsl_pkg::WindowLength; k++) window_q[c][k] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      offer_sample(DirectedRows[i].ch, DirectedRows[i].smp, DirectedRows[i].known,
                   DirectedRows[i].avg, DirectedRows[i].dist_cm);
    end

    // Mostly level runs long enough to settle the window, some pure noise
    while (items_accepted < ItemTotal) begin
      if ($urandom_range(0, 9) < 7) begin
        lane    = 1'($urandom_range(0, 1));
        level   = pick_level();
        run_len = $urandom_range(arsl_pkg::WindowLength, arsl_pkg::WindowLength + 4);
        for (int k = 0; k < run_len && items_accepted < ItemTotal; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            offer_sample(!lane, arsl_pkg::SampleW'($urandom_range(0, 1023)),
                         1'b0, '0, '0);
          end else begin
            v = level;
            if ($urandom_range(0, 3) == 0) v = level + int'($urandom_range(0, 2)) - 1;
            v = (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
            offer_sample(lane, arsl_pkg::SampleW'(v), 1'b0, '0, '0);
          end
        end
      end else begin
        repeat ($urandom_range(1, 10)) begin
          if (items_accepted < ItemTotal) begin
            offer_sample(1'($urandom_range(0, 1)),
                         arsl_pkg::SampleW'($urandom_range(0, 1023)),
                         1'b0, '0, '0);
          end
        end
      end
    end

    // Drain, then let the pipeline settle
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Receiver: short random stalls, one long hold-off to back up the block
  initial begin
    int stall_left;
    bit hold_done;
    stall_left  = 0;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && items_accepted >= HoldAt) begin
        stall_left = HoldCycles;
        hold_done  = 1'b1;
      end else if (stall_left == 0 && !tail_quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result check, sampled mid-cycle where outputs are stable
  always @(negedge clk_i) begin
    range_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: channel_out %0d average %0d distance_cm %0d",
               channel_out_o, average_o, distance_cm_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (channel_out_o !== want.ch) begin
          $error("channel_out: expected %0d, got %0d", want.ch, channel_out_o);
          error_count++;
        end
        if (average_o !== want.avg) begin
          $error("average: expected %0d, got %0d", want.avg, average_o);
          error_count++;
        end
        if (distance_cm_o !== want.dist_cm) begin
          $error("distance_cm: expected %0d, got %0d", want.dist_cm, distance_cm_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
